// ===== design/csim_pkg.sv =====
// shared types and constants for the cosine similarity match block
package csim_pkg;

  // longest vector that is accumulated, extra pairs are dropped
  localparam int MAX_VECTOR_LENGTH = 2048;
  localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1);

  // accumulator widths
  localparam int DOT_W = 43;
  localparam int NORM_W = 42;
  localparam int MAG_W = 42;

  // sequential multiplier and root search widths
  localparam int PROD_W = 84;
  localparam int WIDE_W = 116;
  localparam int MUL_STEPS = 42;
  localparam int STEP_W = 6;
  localparam int Q_W = 16;
  localparam int K_W = 4;
  localparam int FRAC_SHIFT = 30;

  // register map
  localparam logic [2:0] ADDR_ENABLE = 3'd0;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd4;
  localparam logic [14:0] THRESHOLD_RESET = 15'd22938;

  // finished accumulation handed from front to back
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0] n1;
    logic [NORM_W-1:0] n2;
  } vec_sums_t;

  // configuration seen by the back end
  typedef struct packed {
    logic enable;
    logic [14:0] threshold;
  } match_cfg_t;

  // queue status between the two halves
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/csim_front.sv =====
// front end: accumulates dot product and norms one pair per cycle while accept is high (low while the queue is full)
module csim_front import csim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic signed [15:0] first_element,
  input  logic signed [15:0] second_element,
  input  logic last_element,
  output logic done,
  output vec_sums_t sums
);

  logic signed [DOT_W-1:0] dot_acc;
  logic [NORM_W-1:0] n1_acc;
  logic [NORM_W-1:0] n2_acc;
  logic [CNT_W-1:0] pair_count;
  logic signed [31:0] prod_ab;
  logic signed [31:0] prod_aa;
  logic signed [31:0] prod_bb;
  logic take;
  vec_sums_t sums_next;

  // element products
  assign prod_ab = first_element * second_element;
  assign prod_aa = first_element * first_element;
  assign prod_bb = second_element * second_element;
  assign take = (pair_count < CNT_W'(MAX_VECTOR_LENGTH));

  // sums including the current pair
  always_comb begin
    sums_next.dot = dot_acc;
    sums_next.n1 = n1_acc;
    sums_next.n2 = n2_acc;
    if (take) begin
      sums_next.dot = dot_acc + DOT_W'(prod_ab);
      sums_next.n1 = n1_acc + NORM_W'(unsigned'(prod_aa));
      sums_next.n2 = n2_acc + NORM_W'(unsigned'(prod_bb));
    end
  end

  assign done = accept && last_element;
  assign sums = sums_next;

  // accumulators, cleared after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
      n1_acc <= '0;
      n2_acc <= '0;
      pair_count <= '0;
    end else if (accept) begin
      if (last_element) begin
        dot_acc <= '0;
        n1_acc <= '0;
        n2_acc <= '0;
        pair_count <= '0;
      end else begin
        dot_acc <= sums_next.dot;
        n1_acc <= sums_next.n1;
        n2_acc <= sums_next.n2;
        if (take) begin
          pair_count <= pair_count + 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/csim_queue.sv =====
// two entry queue of finished sums between front and back
module csim_queue import csim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  vec_sums_t wr_data,
  input  logic rd,
  output vec_sums_t rd_data,
  output queue_status_t status
);

  vec_sums_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign status.full = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== design/csim_back.sv =====
// back end: products, bitwise root search and result register
module csim_back import csim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  queue_status_t qstat,
  input  vec_sums_t qdata,
  output logic qrd,
  input  match_cfg_t cfg,
  input  logic pop,
  output logic empty,
  output logic signed [15:0] similarity,
  output logic is_match
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL_P = 3'd1;
  localparam logic [2:0] S_MUL_D = 3'd2;
  localparam logic [2:0] S_TRIAL = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic neg;
  logic [MAG_W-1:0] mag;
  logic [PROD_W-1:0] mul_a;
  logic [MAG_W-1:0] mul_b;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_next;
  logic [STEP_W-1:0] step;
  logic [WIDE_W-1:0] p;
  logic [WIDE_W-1:0] d;
  logic [WIDE_W-1:0] q2p;
  logic [WIDE_W-1:0] qp;
  logic [WIDE_W-1:0] t;
  logic [Q_W-1:0] q;
  logic [K_W-1:0] k;
  logic out_valid;
  logic signed [15:0] sim_next;
  logic [MAG_W-1:0] dot_abs;

  assign empty = !out_valid;
  assign qrd = (state == S_IDLE) && !qstat.empty;
  assign acc_next = mul_b[0] ? acc + mul_a : acc;
  assign dot_abs = qdata.dot[DOT_W-1] ? MAG_W'(-qdata.dot) : MAG_W'(qdata.dot);

  // sign and saturation of the root search result
  always_comb begin
    if (neg) begin
      sim_next = 16'(-q);
    end else if (q[Q_W-1]) begin
      sim_next = 16'h7fff;
    end else begin
      sim_next = signed'(q);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            neg <= qdata.dot[DOT_W-1];
            mag <= dot_abs;
            mul_a <= PROD_W'(qdata.n1);
            mul_b <= MAG_W'(qdata.n2);
            acc <= '0;
            step <= '0;
            q <= '0;
            if (qdata.n1 == '0 || qdata.n2 == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL_P;
            end
          end
        end
        S_MUL_P: begin
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            p <= WIDE_W'(acc_next);
            mul_a <= PROD_W'(mag);
            mul_b <= mag;
            acc <= '0;
            step <= '0;
            state <= S_MUL_D;
          end else begin
            acc <= acc_next;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
            step <= step + 1'b1;
          end
        end
        S_MUL_D: begin
          acc <= acc_next;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
          step <= step + 1'b1;
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            d <= WIDE_W'(acc_next) << FRAC_SHIFT;
            q2p <= '0;
            qp <= '0;
            k <= K_W'(Q_W - 1);
            state <= S_TRIAL;
          end
        end
        S_TRIAL: begin
          // square of q with bit k set, times the norm product
          t <= q2p + (qp << (k + 1'b1)) + (p << {k, 1'b0});
          state <= S_CMP;
        end
        S_CMP: begin
          if (t <= d) begin
            q2p <= t;
            qp <= qp + (p << k);
            q[k] <= 1'b1;
          end
          if (k == '0) begin
            state <= S_DONE;
          end else begin
            k <= k - 1'b1;
            state <= S_TRIAL;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            similarity <= sim_next;
            is_match <= cfg.enable && !sim_next[15] && (sim_next[14:0] >= cfg.threshold);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/cosine_similarity_threshold_match_top.sv =====
// top level of the cosine similarity threshold match block
//
// Element pairs of two feature vectors enter on the input queue port: a
// transaction happens when push is high and full is low, one pair per cycle.
// The pair with last_element set closes the vector; only then is a result
// produced. Pairs past MAX_VECTOR_LENGTH are dropped but last still closes.
// Results leave on the output queue port: similarity and is_match are valid
// while empty is low and are taken when pop is high.
// The back end runs two 42 step shift-add multiplications (norm product and
// squared dot product) and a 16 bit root search with a trial and a compare
// state per bit. A two entry queue between front and back lets the next
// vector stream in meanwhile; full rises only when that queue holds two
// finished vectors.
// A stalled receiver holds the result register, which in turn stalls the
// back end and eventually the input.
// Reset (rst, synchronous) clears accumulators, queue and the result valid flag,
// and sets match_enable to 1 and match_threshold to 22938. Registers are
// written over the APB port at byte addresses 0 and 4.
module cosine_similarity_threshold_match_top import csim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [15:0] first_element,
  input  logic signed [15:0] second_element,
  input  logic last_element,
  output logic empty,
  input  logic pop,
  output logic signed [15:0] similarity,
  output logic is_match,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  match_cfg_t cfg;
  queue_status_t qstat;
  vec_sums_t sums;
  vec_sums_t qdata;
  logic accept;
  logic done;
  logic qrd;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b1;
      cfg.threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_ENABLE) begin
        cfg.enable <= pwdata[0];
      end else if (paddr == ADDR_THRESHOLD) begin
        cfg.threshold <= pwdata[14:0];
      end
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENABLE) begin
      prdata = {31'd0, cfg.enable};
    end else if (paddr == ADDR_THRESHOLD) begin
      prdata = {17'd0, cfg.threshold};
    end
  end

  assign full = qstat.full;
  assign accept = push && !qstat.full;

  csim_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .first_element(first_element),
    .second_element(second_element),
    .last_element(last_element),
    .done(done),
    .sums(sums)
  );

  csim_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(done),
    .wr_data(sums),
    .rd(qrd),
    .rd_data(qdata),
    .status(qstat)
  );

  csim_back u_back (
    .clk(clk),
    .rst(rst),
    .qstat(qstat),
    .qdata(qdata),
    .qrd(qrd),
    .cfg(cfg),
    .pop(pop),
    .empty(empty),
    .similarity(similarity),
    .is_match(is_match)
  );

endmodule
